[rtl/mlpsa_pkg.sv]
`default_nettype none

package mlpsa_pkg;

  localparam int MAX_TASKS = 32;
  localparam int LEVELS    = 5;

  localparam int IDX_W   = $clog2(MAX_TASKS);
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ID_W    = 5;
  localparam int KIND_W  = 3;
  localparam int FLVL_W  = 3;
  localparam int CTR_W   = 16;
  localparam int STAMP_W = 16;
  localparam int CFG_W   = 16;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_ENQ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_YIELD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PICK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PCHK  = 3'd5;

  // config register indexes
  localparam logic CFG_TIMESLICE = 1'b0;
  localparam logic CFG_AGE_THR   = 1'b1;

  localparam logic [CFG_W-1:0] TIMESLICE_RST = 16'd100;
  localparam logic [CFG_W-1:0] AGE_THR_RST   = 16'd300;

  typedef struct packed {
    logic [LVL_W-1:0]   lvl;
    logic [LVL_W-1:0]   base;
    logic [CTR_W-1:0]   slice;
    logic [CTR_W-1:0]   age;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  function automatic logic [LVL_W-1:0] clamp_lvl(input logic [FLVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    if (int'(v) >= LEVELS) r = LVL_W'(LEVELS - 1);
    else r = LVL_W'(v);
    return r;
  endfunction

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    logic [CTR_W-1:0] r;
    if (v == {CTR_W{1'b1}}) r = v;
    else r = v + CTR_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/multilevel_priority_scheduler_aging_unit.sv]
`default_nettype none
// Multilevel feedback queue scheduler with aging, 32 task slots, 5 levels.
// Input channel: in_valid_i / in_stall_o carries one event (kind, task_id,
// level, base_level); a transfer happens when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i returns exactly one result
// (next_task, next_valid, resched) per event, in order.
// Config: cfg_we_i writes cfg_wdata_i to timeslice (index 0) or
// age_threshold (index 1); write only while the block is idle.
// Slot state lives in one RAM with a registered read, swept one slot per
// cycle. Dequeue and invalid events go straight to the result; enqueue,
// yield and tick first update one slot; preempt check reads two slots; a
// pick sweeps all slots once; a tick then sweeps all slots to age them,
// and once more for each task that rises a level (one stamp sweep each).
// One event is in work at a time; the next is accepted once the current one
// has handed its result to the output register, even if that register
// still waits on a stalled receiver.
// Reset: timeslice 100, threshold 300, all slots unqueued, counters zero.
// A stalled receiver holds the result; a finished event waits for it.
module multilevel_priority_scheduler_aging_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mlpsa_pkg::KIND_W-1:0]        kind_i,
  input  logic [mlpsa_pkg::ID_W-1:0]          task_id_i,
  input  logic [mlpsa_pkg::FLVL_W-1:0]        level_i,
  input  logic [mlpsa_pkg::FLVL_W-1:0]        base_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mlpsa_pkg::ID_W-1:0]          next_task_o,
  output logic                                next_valid_o,
  output logic                                resched_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [mlpsa_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int IDX_W = mlpsa_pkg::IDX_W;
  localparam int CNT_W = mlpsa_pkg::CNT_W;
  localparam int LVL_W = mlpsa_pkg::LVL_W;
  localparam int NT    = mlpsa_pkg::MAX_TASKS;

  typedef enum logic [3:0] {
    S_IDLE, S_RMW, S_AGE, S_SEL, S_SEL_WB, S_PICK, S_PC1, S_PC2, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [mlpsa_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [IDX_W-1:0]              id_q, id_d;
  logic [LVL_W-1:0]              lvl_in_q, lvl_in_d, base_in_q, base_in_d;
  logic [IDX_W-1:0]              cur_q, cur_d;
  logic [mlpsa_pkg::STAMP_W-1:0] stamp_q, stamp_d;
  logic [mlpsa_pkg::CFG_W-1:0]   ts_q, ts_d, thr_q, thr_d;
  logic [NT-1:0]                 queued_q, queued_d;
  logic [NT-1:0]                 touched_q, touched_d;
  logic [NT-1:0]                 raised_q, raised_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          pv_q, pv_d;
  logic [IDX_W-1:0]              pidx_q, pidx_d;
  logic                          best_vld_q, best_vld_d;
  logic [IDX_W-1:0]              best_idx_q, best_idx_d;
  mlpsa_pkg::ent_t               best_ent_q, best_ent_d;
  logic [mlpsa_pkg::STAMP_W-1:0] best_wait_q, best_wait_d;
  logic [LVL_W-1:0]              lvl_cur_q, lvl_cur_d;
  logic [LVL_W-1:0]              lvl_id_q, lvl_id_d;
  logic [IDX_W-1:0]              raddr_q;
  logic [IDX_W-1:0]              res_task_q, res_task_d;
  logic                          res_nv_q, res_nv_d, res_rs_q, res_rs_d;
  logic                          out_valid_q, out_valid_d;
  logic [mlpsa_pkg::ID_W-1:0]    out_task_q, out_task_d;
  logic                          out_nv_q, out_nv_d, out_rs_q, out_rs_d;

  // RAM port
  logic                          we;
  logic [IDX_W-1:0]              waddr, raddr;
  mlpsa_pkg::ent_t               wdata;
  logic [mlpsa_pkg::ENT_W-1:0]   rdata;
  mlpsa_pkg::ent_t               e_m;

  logic                          id_ok, sweep_end, cand;
  logic [mlpsa_pkg::STAMP_W-1:0] wait_v;
  mlpsa_pkg::ent_t               w;

  mlpsa_ram #(
    .DEPTH (NT),
    .WIDTH (mlpsa_pkg::ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Slots never written read with zero slice and aging counts.
  always_comb begin
    e_m = mlpsa_pkg::ent_t'(rdata);
    if (!touched_q[raddr_q]) begin
      e_m.slice = '0;
      e_m.age   = '0;
    end
  end

  assign id_ok     = int'(task_id_i) < NT;
  assign sweep_end = (cnt_q == CNT_W'(NT));
  assign wait_v    = stamp_q - e_m.stamp;
  assign cand      = pv_q && ((state_q == S_SEL) ? raised_q[pidx_q] : queued_q[pidx_q]);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    id_d        = id_q;
    lvl_in_d    = lvl_in_q;
    base_in_d   = base_in_q;
    cur_d       = cur_q;
    stamp_d     = stamp_q;
    ts_d        = ts_q;
    thr_d       = thr_q;
    queued_d    = queued_q;
    touched_d   = touched_q;
    raised_d    = raised_q;
    cnt_d       = cnt_q;
    pv_d        = pv_q;
    pidx_d      = pidx_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_ent_d  = best_ent_q;
    best_wait_d = best_wait_q;
    lvl_cur_d   = lvl_cur_q;
    lvl_id_d    = lvl_id_q;
    res_task_d  = res_task_q;
    res_nv_d    = res_nv_q;
    res_rs_d    = res_rs_q;
    out_valid_d = out_valid_q;
    out_task_d  = out_task_q;
    out_nv_d    = out_nv_q;
    out_rs_d    = out_rs_q;
    we          = 1'b0;
    waddr       = pidx_q;
    raddr       = cnt_q[IDX_W-1:0];
    w           = e_m;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        mlpsa_pkg::CFG_TIMESLICE: ts_d  = cfg_wdata_i;
        mlpsa_pkg::CFG_AGE_THR:   thr_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    // sweep sequencing: read slot cnt, process slot pidx in the cycle after
    if (state_q == S_AGE || state_q == S_SEL || state_q == S_PICK) begin
      if (!sweep_end) cnt_d = cnt_q + CNT_W'(1);
      pv_d   = !sweep_end;
      pidx_d = cnt_q[IDX_W-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d    = kind_i;
          id_d      = IDX_W'(task_id_i);
          lvl_in_d  = mlpsa_pkg::clamp_lvl(level_i);
          base_in_d = mlpsa_pkg::clamp_lvl(base_level_i);
          res_task_d = '0;
          res_nv_d   = 1'b0;
          res_rs_d   = 1'b0;
          state_d    = S_DONE;
          case (kind_i)
            mlpsa_pkg::KIND_ENQ: begin
              if (id_ok) begin
                raddr   = IDX_W'(task_id_i);
                state_d = S_RMW;
              end
            end
            mlpsa_pkg::KIND_DEQ: begin
              if (id_ok) queued_d[IDX_W'(task_id_i)] = 1'b0;
            end
            mlpsa_pkg::KIND_YIELD, mlpsa_pkg::KIND_TICK: begin
              raddr   = cur_q;
              state_d = S_RMW;
            end
            mlpsa_pkg::KIND_PICK: begin
              cnt_d      = '0;
              pv_d       = 1'b0;
              best_vld_d = 1'b0;
              state_d    = S_PICK;
            end
            mlpsa_pkg::KIND_PCHK: begin
              if (id_ok) begin
                raddr   = IDX_W'(task_id_i);
                state_d = S_PC1;
              end
            end
            default: ;
          endcase
        end
      end

      S_RMW: begin
        we    = 1'b1;
        waddr = (kind_q == mlpsa_pkg::KIND_ENQ) ? id_q : cur_q;
        touched_d[waddr] = 1'b1;
        state_d = S_DONE;
        case (kind_q)
          mlpsa_pkg::KIND_ENQ: begin
            w.lvl   = lvl_in_q;
            w.base  = base_in_q;
            w.stamp = stamp_q;
            if (e_m.slice >= ts_q) w.slice = '0;
            queued_d[id_q] = 1'b1;
            stamp_d = stamp_q + mlpsa_pkg::STAMP_W'(1);
          end
          mlpsa_pkg::KIND_YIELD: begin
            if (e_m.age >= thr_q) begin
              w.age = '0;
              w.lvl = e_m.base;
            end
            w.stamp = stamp_q;
            if (e_m.slice >= ts_q) w.slice = '0;
            queued_d[cur_q] = 1'b1;
            stamp_d = stamp_q + mlpsa_pkg::STAMP_W'(1);
          end
          default: begin
            // tick: charge the running task's slice
            w.slice = mlpsa_pkg::sat_inc(e_m.slice);
            if (w.slice >= ts_q) begin
              w.lvl   = e_m.base;
              w.age   = '0;
              w.stamp = stamp_q;
              w.slice = '0;
              queued_d[cur_q] = 1'b1;
              stamp_d  = stamp_q + mlpsa_pkg::STAMP_W'(1);
              res_rs_d = 1'b1;
            end
            lvl_cur_d = w.lvl;
            cnt_d     = '0;
            pv_d      = 1'b0;
            state_d   = S_AGE;
          end
        endcase
      end

      S_AGE: begin
        if (pv_q && queued_q[pidx_q] && e_m.lvl != '0) begin
          w.age = mlpsa_pkg::sat_inc(e_m.age);
          if (w.age >= thr_q) begin
            w.age = '0;
            w.lvl = e_m.lvl - LVL_W'(1);
            raised_d[pidx_q] = 1'b1;
            // rises above the running task, or is the running task
            if (pidx_q == cur_q || w.lvl < lvl_cur_q) res_rs_d = 1'b1;
          end
          we = 1'b1;
          touched_d[pidx_q] = 1'b1;
        end
        if (sweep_end) begin
          cnt_d      = '0;
          best_vld_d = 1'b0;
          state_d    = (raised_d != '0) ? S_SEL : S_DONE;
        end
      end

      S_SEL, S_PICK: begin
        // best = lowest level, then longest wait, then lowest slot
        if (cand && (!best_vld_q || e_m.lvl < best_ent_q.lvl ||
                     (e_m.lvl == best_ent_q.lvl && wait_v > best_wait_q))) begin
          best_vld_d  = 1'b1;
          best_idx_d  = pidx_q;
          best_ent_d  = e_m;
          best_wait_d = wait_v;
        end
        if (sweep_end) begin
          if (state_q == S_SEL) begin
            state_d = S_SEL_WB;
          end else begin
            if (best_vld_d) begin
              cur_d      = best_idx_d;
              res_task_d = best_idx_d;
              res_nv_d   = 1'b1;
            end
            state_d = S_DONE;
          end
        end
      end

      S_SEL_WB: begin
        // risen tasks go to their new tail in queue order
        w       = best_ent_q;
        w.stamp = stamp_q;
        if (best_ent_q.slice >= ts_q) w.slice = '0;
        we      = 1'b1;
        waddr   = best_idx_q;
        stamp_d = stamp_q + mlpsa_pkg::STAMP_W'(1);
        raised_d[best_idx_q] = 1'b0;
        cnt_d      = '0;
        pv_d       = 1'b0;
        best_vld_d = 1'b0;
        state_d    = (raised_d != '0) ? S_SEL : S_DONE;
      end

      S_PC1: begin
        lvl_id_d = e_m.lvl;
        raddr    = cur_q;
        state_d  = S_PC2;
      end

      S_PC2: begin
        res_rs_d = lvl_id_q < e_m.lvl;
        state_d  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_task_d  = mlpsa_pkg::ID_W'(res_task_q);
          out_nv_d    = res_nv_q;
          out_rs_d    = res_rs_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    wdata = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      stamp_q     <= '0;
      ts_q        <= mlpsa_pkg::TIMESLICE_RST;
      thr_q       <= mlpsa_pkg::AGE_THR_RST;
      queued_q    <= '0;
      touched_q   <= '0;
      raised_q    <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      best_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      stamp_q     <= stamp_d;
      ts_q        <= ts_d;
      thr_q       <= thr_d;
      queued_q    <= queued_d;
      touched_q   <= touched_d;
      raised_q    <= raised_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      best_vld_q  <= best_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    id_q        <= id_d;
    lvl_in_q    <= lvl_in_d;
    base_in_q   <= base_in_d;
    pidx_q      <= pidx_d;
    best_idx_q  <= best_idx_d;
    best_ent_q  <= best_ent_d;
    best_wait_q <= best_wait_d;
    lvl_cur_q   <= lvl_cur_d;
    lvl_id_q    <= lvl_id_d;
    raddr_q     <= raddr;
    res_task_q  <= res_task_d;
    res_nv_q    <= res_nv_d;
    res_rs_q    <= res_rs_d;
    out_task_q  <= out_task_d;
    out_nv_q    <= out_nv_d;
    out_rs_q    <= out_rs_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign next_task_o  = out_task_q;
  assign next_valid_o = out_nv_q;
  assign resched_o    = out_rs_q;

endmodule

`default_nettype wire

[rtl/mlpsa_ram.sv]
`default_nettype none

module mlpsa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/mlpsa_chk.sv]
`default_nettype none

module mlpsa_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [mlpsa_pkg::ID_W-1:0]   next_task_o,
  input logic                         next_valid_o,
  input logic                         resched_o
);

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // one event at a time: a transfer in closes the input
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second event taken while busy");

  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !next_valid_o |-> next_task_o == '0)
    else $error("task reported without a valid pick");

  // a pick never asks for a reschedule
  a_pick_rs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(next_valid_o && resched_o))
    else $error("pick with resched");

endmodule

bind multilevel_priority_scheduler_aging_unit mlpsa_chk u_chk (.*);

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

  // kinds that the block must ignore
  localparam logic [mlpsa_pkg::KIND_W-1:0] KIND_NOP6 = 3'd6;
  localparam logic [mlpsa_pkg::KIND_W-1:0] KIND_NOP7 = 3'd7;
  localparam int NTASK = mlpsa_pkg::MAX_TASKS;
  localparam int NLVL  = mlpsa_pkg::LEVELS;

  typedef struct packed {
    logic [mlpsa_pkg::KIND_W-1:0] kind;
    logic [mlpsa_pkg::ID_W-1:0]   id;
    logic [mlpsa_pkg::FLVL_W-1:0] lvl;
    logic [mlpsa_pkg::FLVL_W-1:0] base;
  } sched_ev_t;

  typedef struct packed {
    logic [mlpsa_pkg::ID_W-1:0] nxt;
    logic                       nv;
    logic                       rs;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [mlpsa_pkg::KIND_W-1:0] kind_i = '0;
  logic [mlpsa_pkg::ID_W-1:0] task_id_i = '0;
  logic [mlpsa_pkg::FLVL_W-1:0] level_i = '0;
  logic [mlpsa_pkg::FLVL_W-1:0] base_level_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [mlpsa_pkg::ID_W-1:0] next_task_o;
  logic next_valid_o;
  logic resched_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [mlpsa_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  always #2 clk_i = ~clk_i;

  multilevel_priority_scheduler_aging_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .task_id_i,
    .level_i, .base_level_i, .out_valid_o, .out_stall_i, .next_task_o,
    .next_valid_o, .resched_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // ---------------------------------------------------------------------
  // Scheduler mirror: slot table, stamp counter, current task, registers
  // ---------------------------------------------------------------------
  logic [15:0] m_tslice, m_age_thr;
  logic        m_queued [NTASK];
  int          m_lvl    [NTASK];
  int          m_base   [NTASK];
  logic [15:0] m_slice  [NTASK];
  logic [15:0] m_age    [NTASK];
  logic [15:0] m_stamp  [NTASK];
  logic [15:0] m_stamp_ctr;
  int          m_cur;

  function automatic int wait_of(int t);
    logic [15:0] d;
    d = m_stamp_ctr - m_stamp[t];
    return int'(d);
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int clamp(logic [mlpsa_pkg::FLVL_W-1:0] v);
    return (int'(v) >= NLVL) ? NLVL - 1 : int'(v);
  endfunction

  // put a slot at the tail of its level with a fresh stamp
  task automatic requeue(int t);
    m_queued[t] = 1'b1;
    m_stamp[t] = m_stamp_ctr;
    m_stamp_ctr = m_stamp_ctr + 16'd1;
    if (m_slice[t] >= m_tslice) m_slice[t] = '0;
  endtask

  task automatic run_tick(output logic rs);
    int idx [NTASK];
    int key [NTASK];
    int n, j, k, t, cur;
    cur = m_cur;
    rs = 1'b0;
    m_slice[cur] = sat16(m_slice[cur]);
    if (m_slice[cur] >= m_tslice) begin
      m_lvl[cur] = m_base[cur];
      m_age[cur] = '0;
      requeue(cur);
      rs = 1'b1;
    end
    // age levels 1 and up, each level visited in FIFO order
    for (int lv = 1; lv < NLVL; lv++) begin
      n = 0;
      for (t = 0; t < NTASK; t++) begin
        if (m_queued[t] && m_lvl[t] == lv) begin
          k = wait_of(t);
          j = n;
          while (j > 0 && key[j-1] < k) begin
            idx[j] = idx[j-1];
            key[j] = key[j-1];
            j--;
          end
          idx[j] = t;
          key[j] = k;
          n++;
        end
      end
      for (int i = 0; i < n; i++) begin
        t = idx[i];
        m_age[t] = sat16(m_age[t]);
        if (m_age[t] >= m_age_thr) begin
          m_age[t] = '0;
          m_lvl[t] = lv - 1;
          requeue(t);
          if (t == cur || m_lvl[t] < m_lvl[cur]) rs = 1'b1;
        end
      end
    end
  endtask

  task automatic sched_predict(input sched_ev_t e, output sched_res_t r);
    int t, cur, best, bl, bw;
    t = int'(e.id);
    cur = m_cur;
    r = '0;
    case (e.kind)
      mlpsa_pkg::KIND_ENQ: begin
        m_lvl[t] = clamp(e.lvl);
        m_base[t] = clamp(e.base);
        requeue(t);
      end
      mlpsa_pkg::KIND_DEQ: m_queued[t] = 1'b0;
      mlpsa_pkg::KIND_YIELD: begin
        m_queued[cur] = 1'b0;
        if (m_age[cur] >= m_age_thr) begin
          m_age[cur] = '0;
          m_lvl[cur] = m_base[cur];
        end
        requeue(cur);
      end
      mlpsa_pkg::KIND_TICK: run_tick(r.rs);
      mlpsa_pkg::KIND_PICK: begin
        best = 0; bl = 0; bw = 0;
        for (int u = 0; u < NTASK; u++) begin
          if (m_queued[u] &&
              (!r.nv || m_lvl[u] < bl || (m_lvl[u] == bl && wait_of(u) > bw))) begin
            r.nv = 1'b1;
            best = u;
            bl = m_lvl[u];
            bw = wait_of(u);
          end
        end
        if (r.nv) begin
          r.nxt = mlpsa_pkg::ID_W'(best);
          m_cur = best;
        end
      end
      mlpsa_pkg::KIND_PCHK: r.rs = (m_lvl[t] < m_lvl[cur]);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Queues, error count
  // ---------------------------------------------------------------------
  sched_ev_t  pending_ev[$];
  sched_res_t expected_res[$];
  int errors = 0;
  int results_seen = 0;
  bit hold_done = 0;

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: one transfer per item, random gap after each
  // ---------------------------------------------------------------------
  int gap_left = 0;
  always @(posedge clk_i) begin
    sched_res_t r;
    logic vld;
    int gap;
    gap = gap_left;
    vld = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      sched_predict(pending_ev.pop_front(), r);
      expected_res.push_back(r);
      vld = 1'b0;
      // some stretches run back to back
      gap = ((results_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 4);
    end
    if (!vld) begin
      if (gap > 0) gap--;
      else if (pending_ev.size() > 0 && rst_ni) begin
        vld = 1'b1;
        kind_i <= pending_ev[0].kind;
        task_id_i <= pending_ev[0].id;
        level_i <= pending_ev[0].lvl;
        base_level_i <= pending_ev[0].base;
      end
    end
    gap_left <= gap;
    in_valid_i <= vld;
  end

  // ---------------------------------------------------------------------
  // Monitor: check each transfer, then a random stall; once a long
  // hold-off so the block fills up and stalls its input
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk_i) begin
    sched_res_t exp_r;
    int hold;
    hold = stall_left;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_r = expected_res.pop_front();
        if (next_task_o !== exp_r.nxt)
          report($sformatf("next_task %0d, want %0d", next_task_o, exp_r.nxt));
        if (next_valid_o !== exp_r.nv)
          report($sformatf("next_valid %0b, want %0b", next_valid_o, exp_r.nv));
        if (resched_o !== exp_r.rs)
          report($sformatf("resched %0b, want %0b", resched_o, exp_r.rs));
      end
      if (!hold_done && results_seen >= 300) begin
        hold = 300;
        hold_done = 1;
      end else begin
        hold = ((results_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 4);
      end
    end
    if (hold > 0) begin
      hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    stall_left <= hold;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  bit ever_enq [NTASK];

  task automatic add_ev(logic [mlpsa_pkg::KIND_W-1:0] k, int id, int lv, int bs);
    sched_ev_t e;
    e.kind = k;
    e.id = mlpsa_pkg::ID_W'(id);
    e.lvl = mlpsa_pkg::FLVL_W'(lv);
    e.base = mlpsa_pkg::FLVL_W'(bs);
    if (k == mlpsa_pkg::KIND_ENQ) ever_enq[id] = 1;
    pending_ev.push_back(e);
  endtask

  task automatic drain();
    while (pending_ev.size() > 0 || expected_res.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == mlpsa_pkg::CFG_TIMESLICE) m_tslice = val;
    else m_age_thr = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // id of a slot that has seen an enqueue, so its levels are defined
  function automatic int known_slot();
    int t;
    do t = $urandom_range(0, NTASK - 1); while (!ever_enq[t]);
    return t;
  endfunction

  task automatic random_events(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)
        add_ev(mlpsa_pkg::KIND_ENQ, $urandom_range(0, 31), $urandom_range(0, 7),
               $urandom_range(0, 7));
      else if (roll < 33) add_ev(mlpsa_pkg::KIND_DEQ, $urandom_range(0, 31), 0, 0);
      else if (roll < 42) add_ev(mlpsa_pkg::KIND_YIELD, $urandom_range(0, 31), 0, 0);
      else if (roll < 67) add_ev(mlpsa_pkg::KIND_TICK, $urandom_range(0, 31), 0, 0);
      else if (roll < 88) add_ev(mlpsa_pkg::KIND_PICK, $urandom_range(0, 31), 0, 0);
      else if (roll < 97)
        add_ev(mlpsa_pkg::KIND_PCHK, known_slot(), $urandom_range(0, 7),
               $urandom_range(0, 7));
      else
        add_ev(roll[0] ? KIND_NOP6 : KIND_NOP7, $urandom_range(0, 31),
               $urandom_range(0, 7), $urandom_range(0, 7));
    end
  endtask

  initial begin
    m_tslice = mlpsa_pkg::TIMESLICE_RST;
    m_age_thr = mlpsa_pkg::AGE_THR_RST;
    m_stamp_ctr = '0;
    m_cur = 0;
    for (int t = 0; t < NTASK; t++) begin
      m_queued[t] = 1'b0; m_lvl[t] = 0; m_base[t] = 0;
      m_slice[t] = '0; m_age[t] = '0; m_stamp[t] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: slot 0 first so the reset current task is defined
    add_ev(mlpsa_pkg::KIND_ENQ, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_ENQ, 31, 7, 7);        // level above range saturates
    add_ev(mlpsa_pkg::KIND_ENQ, 5, 2, 4);
    add_ev(mlpsa_pkg::KIND_ENQ, 5, 3, 1);         // re-enqueue of a queued task
    add_ev(mlpsa_pkg::KIND_PICK, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_PCHK, 31, 0, 0);
    add_ev(mlpsa_pkg::KIND_PCHK, 5, 0, 0);
    add_ev(mlpsa_pkg::KIND_TICK, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_YIELD, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_DEQ, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_PICK, 0, 0, 0);
    add_ev(KIND_NOP6, 17, 5, 6);
    add_ev(KIND_NOP7, 31, 7, 7);
    add_ev(mlpsa_pkg::KIND_DEQ, 31, 0, 0);
    add_ev(mlpsa_pkg::KIND_DEQ, 5, 0, 0);
    add_ev(mlpsa_pkg::KIND_DEQ, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_PICK, 0, 0, 0);        // empty pick
    add_ev(mlpsa_pkg::KIND_TICK, 0, 0, 0);
    drain();

    // short slice and threshold: expiry and aging on every tick
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'd1);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'd1);
    add_ev(mlpsa_pkg::KIND_ENQ, 10, 4, 2);
    add_ev(mlpsa_pkg::KIND_ENQ, 11, 3, 3);
    add_ev(mlpsa_pkg::KIND_PICK, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_TICK, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_TICK, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_YIELD, 0, 0, 0);
    add_ev(mlpsa_pkg::KIND_PICK, 0, 0, 0);
    drain();

    random_events(250);
    drain();
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'd3);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'd6);
    random_events(250);
    drain();
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'hFFFF);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'hFFFF);
    random_events(200);
    drain();
    // zero registers expire on every tick
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'd0);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'd0);
    random_events(150);
    drain();
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'd5);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'd20);
    random_events(250);
    drain();
    write_cfg(mlpsa_pkg::CFG_TIMESLICE, 16'd100);
    write_cfg(mlpsa_pkg::CFG_AGE_THR, 16'd300);
    random_events(150);
    drain();
    repeat (60) @(posedge clk_i);

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
